### hdl/ssps_pkg.sv
// Shared types and constants for the stage schedule parser/sequencer.
// Used by ssps_front, ssps_queue, ssps_back and the top level; no dependencies.
`default_nettype none

package ssps_pkg;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [31:0] light_pattern;
        logic [2:0]  stage_number;
        logic        running;
        logic [1:0]  packet_status;
    } result_t;

    localparam logic [1:0] CMD_BYTE = 2'd0;
    localparam logic [1:0] CMD_END  = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;

    localparam logic [1:0] ST_NONE   = 2'd0;
    localparam logic [1:0] ST_ACCEPT = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;

    localparam logic [1:0] SOF_NONE   = 2'd0;
    localparam logic [1:0] SOF_GOT_S  = 2'd1;
    localparam logic [1:0] SOF_GOT_SO = 2'd2;
    localparam logic [1:0] SOF_FOUND  = 2'd3;

    localparam logic [7:0] SOF_B0 = 8'h53;
    localparam logic [7:0] SOF_B1 = 8'h4F;
    localparam logic [7:0] SOF_B2 = 8'h46;

    localparam int HEADER_BYTES = 4;
    localparam int COUNT_POS    = 2;

    // Slot index field sized for the largest supported slot count (16).
    localparam int SLOT_W      = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [2:0] OP_NOP    = 3'd0;
    localparam logic [2:0] OP_COUNT  = 3'd1;
    localparam logic [2:0] OP_TIME   = 3'd2;
    localparam logic [2:0] OP_PAT    = 3'd3;
    localparam logic [2:0] OP_ACCEPT = 3'd4;
    localparam logic [2:0] OP_REJECT = 3'd5;
    localparam logic [2:0] OP_TICK   = 3'd6;

    typedef struct packed {
        logic [2:0]        kind;
        logic [SLOT_W-1:0] slot;
        logic [31:0]       data;
    } seq_op_t;

endpackage

`default_nettype wire

### hdl/ssps_front.sv
// Front end: SOF search, header/word assembly, packet end classification.
// Emits one seq_op_t per transfer. Depends on ssps_pkg.
`default_nettype none

module ssps_front #(
    parameter int BUFFER_BYTES = 256,
    parameter int STAGE_SLOTS  = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              take,
    input  wire ssps_pkg::item_t   item,
    output ssps_pkg::seq_op_t      op
);
    import ssps_pkg::*;

    localparam int LAYOUT_BYTES = HEADER_BYTES + 8 * STAGE_SLOTS;
    localparam int PBC_W        = $clog2(BUFFER_BYTES + 1);
    localparam int BAS_W        = $clog2(LAYOUT_BYTES + 1);
    localparam int WIDX_W       = BAS_W - 2;

    logic [1:0]        sof_reg, sof_next;
    logic [BAS_W-1:0]  bas_reg, bas_next;
    logic [PBC_W-1:0]  pbc_reg, pbc_next;
    logic [23:0]       wa_reg, wa_next;

    logic [BAS_W-1:0]  k;
    logic [WIDX_W-1:0] widx;
    logic [WIDX_W-1:0] wslot;
    logic              is_time;
    logic [7:0]        dbyte;

    always_comb
    begin
        sof_next = sof_reg;
        bas_next = bas_reg;
        pbc_next = pbc_reg;
        wa_next  = wa_reg;
        op.kind  = OP_NOP;
        op.slot  = '0;
        op.data  = '0;
        dbyte    = item.data_byte;
        k        = bas_reg - BAS_W'(HEADER_BYTES);
        widx     = k[BAS_W-1:2];
        is_time  = widx < WIDX_W'(STAGE_SLOTS);
        wslot    = is_time ? widx : widx - WIDX_W'(STAGE_SLOTS);
        unique case (item.command)
            CMD_BYTE:
            begin
                if (pbc_reg < PBC_W'(BUFFER_BYTES))
                begin
                    pbc_next = pbc_reg + 1'b1;
                    if (sof_reg != SOF_FOUND)
                    begin
                        if (sof_reg == SOF_GOT_S && dbyte == SOF_B1)
                            sof_next = SOF_GOT_SO;
                        else if (sof_reg == SOF_GOT_SO && dbyte == SOF_B2)
                            sof_next = SOF_FOUND;
                        else if (dbyte == SOF_B0)
                            sof_next = SOF_GOT_S;
                        else
                            sof_next = SOF_NONE;
                    end
                    else if (bas_reg < BAS_W'(LAYOUT_BYTES))
                    begin
                        bas_next = bas_reg + 1'b1;
                        if (bas_reg == BAS_W'(COUNT_POS))
                        begin
                            op.kind = OP_COUNT;
                            op.data = {24'd0, dbyte};
                        end
                        else if (bas_reg >= BAS_W'(HEADER_BYTES))
                        begin
                            if (k[1:0] != 2'd3)
                                wa_next = {wa_reg[15:0], dbyte};
                            else
                            begin
                                op.kind = is_time ? OP_TIME : OP_PAT;
                                op.slot = SLOT_W'(wslot);
                                op.data = {wa_reg, dbyte};
                                wa_next = '0;
                            end
                        end
                    end
                end
            end
            CMD_END:
            begin
                op.kind  = (sof_reg == SOF_FOUND && bas_reg >= BAS_W'(HEADER_BYTES))
                         ? OP_ACCEPT : OP_REJECT;
                sof_next = SOF_NONE;
                bas_next = '0;
                pbc_next = '0;
                wa_next  = '0;
            end
            CMD_TICK:
                op.kind = OP_TICK;
            default:
                op.kind = OP_NOP;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sof_reg <= SOF_NONE;
            bas_reg <= '0;
            pbc_reg <= '0;
            wa_reg  <= '0;
        end
        else if (take)
        begin
            sof_reg <= sof_next;
            bas_reg <= bas_next;
            pbc_reg <= pbc_next;
            wa_reg  <= wa_next;
        end
    end

endmodule

`default_nettype wire

### hdl/ssps_queue.sv
// Short register FIFO of seq_op_t between front and back ends.
// Depends on ssps_pkg.
`default_nettype none

module ssps_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire ssps_pkg::seq_op_t wr,
    output logic                   full,
    input  wire logic              pop,
    output ssps_pkg::seq_op_t      rd,
    output logic                   rd_valid
);
    import ssps_pkg::*;

    localparam int PW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNW = $clog2(QUEUE_DEPTH + 1);

    seq_op_t          mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNW-1:0]   cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full     = cnt_reg == CNW'(QUEUE_DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign rd       = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wr;
    end

endmodule

`default_nettype wire

### hdl/ssps_back.sv
// Back end: staged/committed schedule stores, stage sequencer, result register.
// Depends on ssps_pkg.
`default_nettype none

module ssps_back #(
    parameter int STAGE_SLOTS = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ssps_pkg::seq_op_t head,
    input  wire logic              head_valid,
    output logic                   pop,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output ssps_pkg::result_t      result
);
    import ssps_pkg::*;

    localparam int CW    = (STAGE_SLOTS > 1) ? $clog2(STAGE_SLOTS) : 1;
    localparam int CNT_W = $clog2(STAGE_SLOTS + 1);
    localparam int CMP_W = CW + 1;

    logic [31:0]            st_time_reg [STAGE_SLOTS];
    logic [31:0]            st_pat_reg  [STAGE_SLOTS];
    logic [STAGE_SLOTS-1:0] st_time_ok_reg;
    logic [STAGE_SLOTS-1:0] st_pat_ok_reg;
    logic [7:0]             st_count_reg;

    logic [31:0]            times_reg [STAGE_SLOTS];
    logic [31:0]            pats_reg  [STAGE_SLOTS];

    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   sched_valid_reg, sched_valid_next;
    logic [CW-1:0]          cur_reg, cur_next;
    logic [31:0]            rem_reg, rem_next;
    logic [31:0]            shown_reg, shown_next;
    logic                   active_reg, active_next;

    result_t                result_reg;
    logic                   result_valid_reg;

    logic                   do_count, do_time, do_pat, do_accept, do_reject, do_tick;
    logic [CW-1:0]          wslot;
    logic                   start;
    logic [31:0]            rem_now;
    logic [CMP_W-1:0]       cur_inc;
    logic [1:0]             status;

    assign pop          = head_valid && (!result_valid_reg || !result_stall);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign wslot        = head.slot[CW-1:0];

    always_comb
    begin
        do_count  = 1'b0;
        do_time   = 1'b0;
        do_pat    = 1'b0;
        do_accept = 1'b0;
        do_reject = 1'b0;
        do_tick   = 1'b0;
        unique case (head.kind)
            OP_COUNT:  do_count  = 1'b1;
            OP_TIME:   do_time   = 1'b1;
            OP_PAT:    do_pat    = 1'b1;
            OP_ACCEPT: do_accept = 1'b1;
            OP_REJECT: do_reject = 1'b1;
            OP_TICK:   do_tick   = 1'b1;
            default:   ;
        endcase
    end

    always_comb
    begin
        count_next       = count_reg;
        sched_valid_next = sched_valid_reg;
        cur_next         = cur_reg;
        rem_next         = rem_reg;
        shown_next       = shown_reg;
        active_next      = active_reg;
        status           = ST_NONE;
        start            = !active_reg && sched_valid_reg && (count_reg != '0);
        rem_now          = start ? times_reg[cur_reg] : rem_reg;
        cur_inc          = {1'b0, cur_reg} + 1'b1;

        if (do_accept)
        begin
            count_next       = (st_count_reg > 8'(STAGE_SLOTS))
                             ? CNT_W'(STAGE_SLOTS) : CNT_W'(st_count_reg);
            sched_valid_next = 1'b1;
            status           = ST_ACCEPT;
        end
        if (do_reject)
            status = ST_REJECT;

        if (do_tick && (start || active_reg))
        begin
            if (start)
                shown_next = pats_reg[cur_reg];
            if (rem_now <= 32'd1)
            begin
                rem_next    = '0;
                active_next = 1'b0;
                cur_next    = (cur_inc >= CMP_W'(count_reg)) ? '0 : cur_inc[CW-1:0];
            end
            else
            begin
                rem_next    = rem_now - 32'd1;
                active_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_time_ok_reg   <= '0;
            st_pat_ok_reg    <= '0;
            st_count_reg     <= '0;
            count_reg        <= '0;
            sched_valid_reg  <= 1'b0;
            cur_reg          <= '0;
            rem_reg          <= '0;
            shown_reg        <= '0;
            active_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                if (do_time)
                    st_time_ok_reg[wslot] <= 1'b1;
                if (do_pat)
                    st_pat_ok_reg[wslot] <= 1'b1;
                if (do_count)
                    st_count_reg <= head.data[7:0];
                if (do_accept || do_reject)
                begin
                    st_time_ok_reg <= '0;
                    st_pat_ok_reg  <= '0;
                    st_count_reg   <= '0;
                end
                count_reg        <= count_next;
                sched_valid_reg  <= sched_valid_next;
                cur_reg          <= cur_next;
                rem_reg          <= rem_next;
                shown_reg        <= shown_next;
                active_reg       <= active_next;
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (do_time)
                st_time_reg[wslot] <= (head.data == 32'd0) ? 32'd1 : head.data;
            if (do_pat)
                st_pat_reg[wslot] <= head.data;
            if (do_accept)
            begin
                for (int i = 0; i < STAGE_SLOTS; i++)
                begin
                    times_reg[i] <= st_time_ok_reg[i] ? st_time_reg[i] : 32'd1;
                    pats_reg[i]  <= st_pat_ok_reg[i] ? st_pat_reg[i] : 32'd0;
                end
            end
            result_reg.light_pattern <= shown_next;
            result_reg.stage_number  <= 3'(cur_next);
            result_reg.running       <= sched_valid_next && (count_next != '0);
            result_reg.packet_status <= status;
        end
    end

    a_active_rem: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg == (rem_reg != 32'd0))
        else $error("stage active flag disagrees with remaining time");

    a_valid_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        sched_valid_reg |=> sched_valid_reg)
        else $error("schedule valid cleared");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STAGE_SLOTS))
        else $error("stage count above slot count");

    a_accept_status: assert property (@(posedge clk) disable iff (!rst_n)
        pop && do_accept |=> result_valid_reg && result_reg.packet_status == ST_ACCEPT)
        else $error("commit did not report accept");

endmodule

`default_nettype wire

### hdl/stage_schedule_parser_sequencer.sv
// Stage schedule parser and sequencer: top level.
// Instantiates ssps_front, ssps_queue and ssps_back; depends on ssps_pkg.
//
// Usage:
//   item channel (item_valid / item_stall / item): one command per transfer,
//   a packet byte, an end of packet or a one millisecond tick.
//   result channel (result_valid / result_stall / result): exactly one result
//   per item, in order: lights, stage index, running flag, packet status.
// Path: a taken item is written into the queue; the back end pops it into
//   the result register once that register is free.
// Throughput: one item per cycle sustained unless results stall; the front
//   end parses bytes combinationally; the back end pops one op per cycle.
// Stall: while result_stall is high on a valid result, the register and the
//   back end stop and the two-entry queue fills; item_stall rises when full.
// Reset: parser, staged schedule, sequencer and handshake state clear at
//   once; the committed schedule stores hold no reset value and are only
//   read after a commit has written every slot.
`default_nettype none

module stage_schedule_parser_sequencer #(
    parameter int BUFFER_BYTES = 256,
    parameter int STAGE_SLOTS  = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire ssps_pkg::item_t   item,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output ssps_pkg::result_t      result
);
    import ssps_pkg::*;

    logic    take;
    logic    q_full;
    logic    q_valid;
    logic    q_pop;
    seq_op_t front_op;
    seq_op_t q_head;

    assign item_stall = q_full;
    assign take       = item_valid && !item_stall;

    ssps_front #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .STAGE_SLOTS  (STAGE_SLOTS)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .item  (item),
        .op    (front_op)
    );

    ssps_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (take),
        .wr       (front_op),
        .full     (q_full),
        .pop      (q_pop),
        .rd       (q_head),
        .rd_valid (q_valid)
    );

    ssps_back #(
        .STAGE_SLOTS (STAGE_SLOTS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (q_head),
        .head_valid   (q_valid),
        .pop          (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire
